// ===== hw/rtl/particle_motion_step_unit_assert.svh =====
// assertion macros shared by the particle motion step rtl
`ifndef PARTICLE_MOTION_STEP_UNIT_ASSERT_SVH
`define PARTICLE_MOTION_STEP_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PMSU_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("pmsu assertion failed");

// next-cycle implication, checked out of reset
`define PMSU_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("pmsu assertion failed");

`endif

// ===== hw/rtl/pmsu_pkg.sv =====
// types, constants and helpers for the particle motion step unit
package pmsu_pkg;

    localparam int QUO_BITS    = 34;
    localparam int DIV_STAGES  = QUO_BITS;
    localparam int KIN_DEPTH   = 5;
    localparam int PIPE_DEPTH  = 3 + DIV_STAGES + 1;

    localparam logic [2:0] REG_FIELD_ACCEL  = 3'd0;
    localparam logic [2:0] REG_FIELD_BOXMIN = 3'd1;
    localparam logic [2:0] REG_FIELD_BOXMAX = 3'd2;
    localparam logic [2:0] REG_END_SCALE    = 3'd3;
    localparam logic [2:0] REG_FLOOR        = 3'd4;
    localparam logic [2:0] REG_LIFE_SPAN    = 3'd5;
    localparam logic [2:0] REG_MODE_FLAGS   = 3'd6;

    localparam int FLAG_MOVE   = 0;
    localparam int FLAG_FIELD  = 1;
    localparam int FLAG_BOUNCE = 2;
    localparam int FLAG_BLEND  = 3;

    localparam logic [62:0] RST_FIELD_ACCEL = 63'd21474836480;
    localparam logic [62:0] RST_BOX_MIN     = 63'd9218872833128528896;
    localparam logic [62:0] RST_BOX_MAX     = 63'd4503601774855168;
    localparam logic [62:0] RST_END_SCALE   = 63'd4503601774855168;
    localparam logic [30:0] RST_LIFE_SPAN   = 31'd196608;
    localparam logic [3:0]  RST_MODE_FLAGS  = 4'd1;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [26:0] q16n_t;

    typedef struct packed {
        logic [62:0]        field_accel;
        logic [62:0]        box_min;
        logic [62:0]        box_max;
        logic [62:0]        end_scale;
        logic signed [31:0] floor_height;
        logic [30:0]        life_span;
        logic [3:0]         mode_flags;
    } pmsu_cfg_t;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [30:0]      age;
    } pmsu_kin_t;

    typedef struct packed {
        logic [30:0]        rem;
        logic [33:0]        quo;
        logic               neg;
        logic               ovf;
        logic signed [23:0] scl;
    } pmsu_div_t;

    // lane k of a packed q11.10 triple, rescaled to q11.16
    function automatic q16n_t unpack_q(input logic [62:0] r, input int k);
        logic [62:0] sh;
        sh = r >> (21 * k);
        return {sh[20:0], 6'b0};
    endfunction

    function automatic q16_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== hw/rtl/pmsu_div_step.sv =====
// one restoring step of the scale blend quotient pipeline
module pmsu_div_step (
    input  logic                aclk,
    input  logic                ce,
    input  logic [30:0]         divisor,
    input  pmsu_pkg::pmsu_div_t d_in,
    output pmsu_pkg::pmsu_div_t d_out
);
    import pmsu_pkg::*;

    pmsu_div_t   d_reg, d_next;
    logic [31:0] trial;
    logic [32:0] diff;

    always_comb begin
        d_next = d_in;
        trial  = {d_in.rem, d_in.quo[33]};
        diff   = {1'b0, trial} - {2'b0, divisor};
        d_next.quo = {d_in.quo[32:0], ~diff[32]};
        d_next.rem = diff[32] ? trial[30:0] : diff[30:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== hw/rtl/pmsu_blend.sv =====
// scale blend path: difference, product with age, floor quotient by life span
module pmsu_blend (
    input  logic                aclk,
    input  logic                ce,
    input  pmsu_pkg::pmsu_cfg_t cfg,
    input  logic [2:0][23:0]    scl_in,
    input  logic [30:0]         age_in,
    output logic [2:0][31:0]    scale_out
);
    import pmsu_pkg::*;

    logic [2:0][27:0] diff_reg, diff_next;
    logic [2:0][23:0] scl1_reg, scl2_reg;
    logic [30:0]      age1_reg;
    logic [2:0][59:0] prod_reg, prod_next;
    pmsu_div_t        div0_reg [3];
    pmsu_div_t        div0_next [3];
    pmsu_div_t        chain [3][DIV_STAGES+1];
    logic [2:0][31:0] scale_reg, scale_next;
    logic [30:0]      life_eff;
    logic             blend_on;

    assign life_eff = (cfg.life_span == '0) ? 31'd1 : cfg.life_span;
    assign blend_on = cfg.mode_flags[FLAG_MOVE] && cfg.mode_flags[FLAG_BLEND];

    always_comb begin
        logic signed [59:0] a, b;
        logic [59:0]        mag;
        for (int k = 0; k < 3; k++) begin
            diff_next[k] = 28'(unpack_q(cfg.end_scale, k)) - 28'($signed(scl_in[k]));
            a = 60'($signed(diff_reg[k]));
            b = 60'($signed({1'b0, age1_reg}));
            prod_next[k] = a * b;
            mag = prod_reg[k][59] ? (60'd0 - prod_reg[k]) : prod_reg[k];
            div0_next[k].rem = 31'(mag[59:34]);
            div0_next[k].quo = mag[33:0];
            div0_next[k].neg = prod_reg[k][59];
            div0_next[k].ovf = ({5'b0, mag[59:34]} >= life_eff);
            div0_next[k].scl = $signed(scl2_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            diff_reg <= diff_next;
            scl1_reg <= scl_in;
            age1_reg <= age_in;
            prod_reg <= prod_next;
            scl2_reg <= scl1_reg;
            for (int k = 0; k < 3; k++) begin
                div0_reg[k] <= div0_next[k];
            end
            scale_reg <= scale_next;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign chain[k][0] = div0_reg[k];
        for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
            pmsu_div_step u_step (
                .aclk    (aclk),
                .ce      (ce),
                .divisor (life_eff),
                .d_in    (chain[k][s]),
                .d_out   (chain[k][s+1])
            );
        end
    end

    always_comb begin
        pmsu_div_t          d;
        logic signed [35:0] q, sum;
        for (int k = 0; k < 3; k++) begin
            d   = chain[k][DIV_STAGES];
            q   = d.neg ? (36'sd0 - ($signed({2'b0, d.quo}) + 36'(|d.rem)))
                        : $signed({2'b0, d.quo});
            sum = 36'(d.scl) + q;
            if (!blend_on) begin
                scale_next[k] = 32'(d.scl);
            end else if (d.ovf) begin
                scale_next[k] = d.neg ? 32'h80000000 : 32'h7fffffff;
            end else begin
                scale_next[k] = sat32(64'(sum));
            end
        end
    end

    assign scale_out = scale_reg;

endmodule

// ===== hw/rtl/pmsu_kin.sv =====
// kinematics path: field kick, position step, floor bounce, age, then alignment delay
module pmsu_kin (
    input  logic                aclk,
    input  logic                ce,
    input  pmsu_pkg::pmsu_cfg_t cfg,
    input  logic [2:0][31:0]    pos_in,
    input  logic [2:0][31:0]    vel_in,
    input  logic [30:0]         age_in,
    input  logic [16:0]         dt_in,
    output pmsu_pkg::pmsu_kin_t kin_out
);
    import pmsu_pkg::*;

    localparam int PAD = PIPE_DEPTH - KIN_DEPTH;

    logic             move_en;
    logic             inside_reg, inside_next;
    logic [2:0][44:0] accp_reg, accp_next;
    logic [2:0][49:0] mv_reg, mv_next;
    logic [16:0]      dt1_reg, dt2_reg;
    pmsu_kin_t        k1_reg, k2_reg, k2_next, k3_reg, k4_reg, k4_next, k5_next;
    pmsu_kin_t        dly_reg [PAD+1];

    assign move_en = cfg.mode_flags[FLAG_MOVE];

    // box test and field product
    always_comb begin
        logic signed [44:0] a, b;
        inside_next = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (!(32'(unpack_q(cfg.box_min, k)) < $signed(pos_in[k]) &&
                  32'(unpack_q(cfg.box_max, k)) > $signed(pos_in[k]))) begin
                inside_next = 1'b0;
            end
            a = 45'(unpack_q(cfg.field_accel, k));
            b = 45'($signed({1'b0, dt_in}));
            accp_next[k] = a * b;
        end
    end

    // velocity kick and age
    always_comb begin
        logic signed [63:0] vsum;
        logic [31:0]        asum;
        k2_next = k1_reg;
        for (int k = 0; k < 3; k++) begin
            vsum = 64'($signed(k1_reg.vel[k])) + 64'($signed(accp_reg[k]) >>> 16);
            if (move_en && cfg.mode_flags[FLAG_FIELD] && inside_reg) begin
                k2_next.vel[k] = sat32(vsum);
            end
        end
        asum = {1'b0, k1_reg.age} + 32'(dt1_reg);
        if (move_en) begin
            k2_next.age = asum[31] ? 31'h7fffffff : asum[30:0];
        end
    end

    // move product
    always_comb begin
        logic signed [49:0] a, b;
        for (int k = 0; k < 3; k++) begin
            a = 50'($signed(k2_reg.vel[k]));
            b = 50'($signed({1'b0, dt2_reg}));
            mv_next[k] = a * b;
        end
    end

    // position step
    always_comb begin
        logic signed [63:0] psum;
        k4_next = k3_reg;
        for (int k = 0; k < 3; k++) begin
            psum = 64'($signed(k3_reg.pos[k])) + 64'($signed(mv_reg[k]) >>> 16);
            if (move_en) begin
                k4_next.pos[k] = sat32(psum);
            end
        end
    end

    // floor bounce: vy becomes -floor(3 vy / 4)
    always_comb begin
        logic signed [35:0] t3, f;
        k5_next = k4_reg;
        t3 = 36'($signed(k4_reg.vel[1])) + (36'($signed(k4_reg.vel[1])) <<< 1);
        f  = t3 >>> 2;
        if (move_en && cfg.mode_flags[FLAG_BOUNCE] &&
            $signed(k4_reg.pos[1]) <= cfg.floor_height) begin
            k5_next.vel[1] = sat32(64'(36'sd0 - f));
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            inside_reg <= inside_next;
            accp_reg   <= accp_next;
            k1_reg     <= '{pos: pos_in, vel: vel_in, age: age_in};
            dt1_reg    <= dt_in;
            k2_reg     <= k2_next;
            dt2_reg    <= dt1_reg;
            mv_reg     <= mv_next;
            k3_reg     <= k2_reg;
            k4_reg     <= k4_next;
            dly_reg[0] <= k5_next;
            for (int i = 1; i <= PAD; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign kin_out = dly_reg[PAD];

endmodule

// ===== hw/rtl/particle_motion_step_unit.sv =====
// top level of the particle motion step unit
`include "particle_motion_step_unit_assert.svh"

// Particle motion step unit. Takes one particle per cycle (position, velocity,
// spawn scale, age and frame time step; position and velocity Q16.16, the rest
// with 16 fraction bits) and returns it after one Euler step if the move flag
// is set: optional field kick inside a box, position move, optional floor
// bounce with 3/4 restitution, optional scale blend over life, and age
// advance, every result saturated. Throughput is one item per clock. The depth
// is set by the scale blend, whose age/life quotient is produced one bit per
// stage over 34 restoring stages; the kinematics path is delayed to match.
// Both channels are valid/ready; the whole pipeline freezes only while a
// finished result waits at the output. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata and must only change while no item is in flight.
module particle_motion_step_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pos_x,
    input  logic [31:0] s_pos_y,
    input  logic [31:0] s_pos_z,
    input  logic [31:0] s_vel_x,
    input  logic [31:0] s_vel_y,
    input  logic [31:0] s_vel_z,
    input  logic [23:0] s_spawn_scale_x,
    input  logic [23:0] s_spawn_scale_y,
    input  logic [23:0] s_spawn_scale_z,
    input  logic [30:0] s_age,
    input  logic [16:0] s_time_step,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_new_pos_x,
    output logic [31:0] m_new_pos_y,
    output logic [31:0] m_new_pos_z,
    output logic [31:0] m_new_vel_x,
    output logic [31:0] m_new_vel_y,
    output logic [31:0] m_new_vel_z,
    output logic [31:0] m_scale_x,
    output logic [31:0] m_scale_y,
    output logic [31:0] m_scale_z,
    output logic [30:0] m_new_age
);
    import pmsu_pkg::*;

    // configuration registers
    pmsu_cfg_t cfg_reg;

    // input stage
    logic [2:0][31:0] pos_reg, vel_reg;
    logic [2:0][23:0] scl_reg;
    logic [30:0]      age_reg;
    logic [16:0]      dt_reg;

    // valid bits, one per stage; the last one is the output register
    logic [PIPE_DEPTH:0] vld_reg;
    logic                ce;

    pmsu_kin_t        kin_out;
    logic [2:0][31:0] scale_out;

    // advance everything unless the output holds an item nobody takes
    assign ce      = !vld_reg[PIPE_DEPTH] || m_ready;
    assign s_ready = ce;
    assign m_valid = vld_reg[PIPE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.field_accel  <= RST_FIELD_ACCEL;
            cfg_reg.box_min      <= RST_BOX_MIN;
            cfg_reg.box_max      <= RST_BOX_MAX;
            cfg_reg.end_scale    <= RST_END_SCALE;
            cfg_reg.floor_height <= '0;
            cfg_reg.life_span    <= RST_LIFE_SPAN;
            cfg_reg.mode_flags   <= RST_MODE_FLAGS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FIELD_ACCEL:  cfg_reg.field_accel  <= cfg_wdata;
                REG_FIELD_BOXMIN: cfg_reg.box_min      <= cfg_wdata;
                REG_FIELD_BOXMAX: cfg_reg.box_max      <= cfg_wdata;
                REG_END_SCALE:    cfg_reg.end_scale    <= cfg_wdata;
                REG_FLOOR:        cfg_reg.floor_height <= $signed(cfg_wdata[31:0]);
                REG_LIFE_SPAN:    cfg_reg.life_span    <= cfg_wdata[30:0];
                REG_MODE_FLAGS:   cfg_reg.mode_flags   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-1:0], s_valid};
        end
    end

    // input capture, no reset on payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            pos_reg <= {s_pos_z, s_pos_y, s_pos_x};
            vel_reg <= {s_vel_z, s_vel_y, s_vel_x};
            scl_reg <= {s_spawn_scale_z, s_spawn_scale_y, s_spawn_scale_x};
            age_reg <= s_age;
            dt_reg  <= s_time_step;
        end
    end

    pmsu_kin u_kin (
        .aclk    (aclk),
        .ce      (ce),
        .cfg     (cfg_reg),
        .pos_in  (pos_reg),
        .vel_in  (vel_reg),
        .age_in  (age_reg),
        .dt_in   (dt_reg),
        .kin_out (kin_out)
    );

    pmsu_blend u_blend (
        .aclk      (aclk),
        .ce        (ce),
        .cfg       (cfg_reg),
        .scl_in    (scl_reg),
        .age_in    (age_reg),
        .scale_out (scale_out)
    );

    assign m_new_pos_x = kin_out.pos[0];
    assign m_new_pos_y = kin_out.pos[1];
    assign m_new_pos_z = kin_out.pos[2];
    assign m_new_vel_x = kin_out.vel[0];
    assign m_new_vel_y = kin_out.vel[1];
    assign m_new_vel_z = kin_out.vel[2];
    assign m_new_age   = kin_out.age;
    assign m_scale_x   = scale_out[0];
    assign m_scale_y   = scale_out[1];
    assign m_scale_z   = scale_out[2];

    // a blocked output must stop the input side
    `PMSU_ASSERT_NOW(a_stall_blocks_in, aclk, aresetn, m_valid && !m_ready, !s_ready)
    // an accepted item lands in the input stage
    `PMSU_ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, vld_reg[0])
    // the last internal stage reaches the output when the pipe moves
    `PMSU_ASSERT_NEXT(a_valid_advances, aclk, aresetn, ce && vld_reg[PIPE_DEPTH-1], m_valid)
    // a frozen pipe keeps every valid bit
    `PMSU_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, !ce, $stable(vld_reg))

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the particle motion step unit
module testbench;
    import pmsu_pkg::*;

    // one particle as offered on the input channel
    typedef struct {
        logic [31:0] px, py, pz, vx, vy, vz;
        logic [23:0] sx, sy, sz;
        logic [30:0] age;
        logic [16:0] dt;
    } particle_t;

    // one updated particle as returned on the output channel
    typedef struct {
        logic [31:0] px, py, pz, vx, vy, vz, sx, sy, sz;
        logic [30:0] age;
    } moved_t;

    // one row of the directed table; check_fixed marks a typed-in result
    typedef struct {
        particle_t p;
        bit        check_fixed;
        moved_t    r;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [62:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_pos_x, s_pos_y, s_pos_z, s_vel_x, s_vel_y, s_vel_z;
    logic [23:0] s_spawn_scale_x, s_spawn_scale_y, s_spawn_scale_z;
    logic [30:0] s_age;
    logic [16:0] s_time_step;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_new_pos_x, m_new_pos_y, m_new_pos_z;
    logic [31:0] m_new_vel_x, m_new_vel_y, m_new_vel_z;
    logic [31:0] m_scale_x, m_scale_y, m_scale_z;
    logic [30:0] m_new_age;

    particle_motion_step_unit dut (.*);

    // configuration mirror
    logic [62:0]        accel_q, box_lo_q, box_hi_q, end_scale_q;
    logic signed [31:0] floor_q;
    logic [30:0]        life_q;
    logic [3:0]         flags_q;

    moved_t expected_particles[$];
    bit     failed;
    bit     quiet;       // no idling on either side
    bit     hold_sink;   // receiver held off for a long stretch
    int     hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100000000;
        $display("[particle_motion_step_unit] ERROR");
        $finish;
    end

    function automatic longint lane_q16(logic [62:0] r, int k);
        logic signed [20:0] f;
        f = r[21*k +: 21];
        return longint'(f) * 64;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor division, den > 0
    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    // one euler step with field kick, bounce and scale blend
    function automatic moved_t step_particle(particle_t p);
        longint pos[3], vel[3], scl[3], age, dt, nage, life, diff;
        bit     in_box;
        moved_t r;
        pos[0] = longint'(signed'(p.px)); pos[1] = longint'(signed'(p.py));
        pos[2] = longint'(signed'(p.pz));
        vel[0] = longint'(signed'(p.vx)); vel[1] = longint'(signed'(p.vy));
        vel[2] = longint'(signed'(p.vz));
        scl[0] = longint'(signed'(p.sx)); scl[1] = longint'(signed'(p.sy));
        scl[2] = longint'(signed'(p.sz));
        age = longint'(p.age);
        dt = longint'(p.dt);
        nage = age;
        if (flags_q[FLAG_MOVE]) begin
            if (flags_q[FLAG_FIELD]) begin
                in_box = 1'b1;
                for (int k = 0; k < 3; k++)
                    if (!(lane_q16(box_lo_q, k) < pos[k] && lane_q16(box_hi_q, k) > pos[k]))
                        in_box = 1'b0;
                if (in_box)
                    for (int k = 0; k < 3; k++)
                        vel[k] = clamp32(vel[k] + ((lane_q16(accel_q, k) * dt) >>> 16));
            end
            for (int k = 0; k < 3; k++)
                pos[k] = clamp32(pos[k] + ((vel[k] * dt) >>> 16));
            if (flags_q[FLAG_BOUNCE] && pos[1] <= longint'(floor_q))
                vel[1] = clamp32(-((vel[1] * 3) >>> 2));
            if (flags_q[FLAG_BLEND]) begin
                life = (life_q == 0) ? 1 : longint'(life_q);
                for (int k = 0; k < 3; k++) begin
                    diff = lane_q16(end_scale_q, k) - scl[k];
                    scl[k] = clamp32(scl[k] + floor_div(diff * age, life));
                end
            end
            nage = age + dt;
            if (nage > 2147483647) nage = 2147483647;
        end
        r.px = pos[0][31:0]; r.py = pos[1][31:0]; r.pz = pos[2][31:0];
        r.vx = vel[0][31:0]; r.vy = vel[1][31:0]; r.vz = vel[2][31:0];
        r.sx = scl[0][31:0]; r.sy = scl[1][31:0]; r.sz = scl[2][31:0];
        r.age = nage[30:0];
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [62:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_FIELD_ACCEL:  accel_q = val;
            REG_FIELD_BOXMIN: box_lo_q = val;
            REG_FIELD_BOXMAX: box_hi_q = val;
            REG_END_SCALE:    end_scale_q = val;
            REG_FLOOR:        floor_q = val[31:0];
            REG_LIFE_SPAN:    life_q = val[30:0];
            default:          flags_q = val[3:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // stop offering, wait until every expected particle has come back, then let the pipe drain
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_particles.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // offer one particle; called at a falling edge, returns at a falling edge
    // valid stays high into the next call so items can follow back to back
    task automatic send_particle(particle_t p, bit fixed, moved_t r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= p.px; s_pos_y <= p.py; s_pos_z <= p.pz;
        s_vel_x <= p.vx; s_vel_y <= p.vy; s_vel_z <= p.vz;
        s_spawn_scale_x <= p.sx; s_spawn_scale_y <= p.sy; s_spawn_scale_z <= p.sz;
        s_age <= p.age;
        s_time_step <= p.dt;
        do @(posedge aclk); while (!s_ready);
        expected_particles.insert(expected_particles.size(), fixed ? r : step_particle(p));
        @(negedge aclk);
    endtask

    function automatic logic [31:0] wide_rand();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 20) << 16;
            3: return -($urandom_range(0, 20) << 16);
            default: return $urandom;
        endcase
    endfunction

    // shaped particle: mostly near the box and floor, sometimes wild
    function automatic particle_t rand_particle();
        particle_t p;
        bit wild;
        wild = ($urandom_range(0, 4) == 0);
        p.px = wild ? wide_rand() : $signed($urandom_range(0, 262144)) - 131072;
        p.py = wild ? wide_rand() : $signed($urandom_range(0, 262144)) - 131072;
        p.pz = wild ? wide_rand() : $signed($urandom_range(0, 262144)) - 131072;
        p.vx = wild ? wide_rand() : $signed($urandom_range(0, 1048576)) - 524288;
        p.vy = wild ? wide_rand() : $signed($urandom_range(0, 1048576)) - 524288;
        p.vz = wild ? wide_rand() : $signed($urandom_range(0, 1048576)) - 524288;
        p.sx = 24'($urandom); p.sy = 24'($urandom); p.sz = 24'($urandom);
        p.age = wild ? 31'($urandom) : 31'($urandom_range(0, 327680));
        p.dt = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        return p;
    endfunction

    // receiver side: random stall bursts, plus one long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_sink = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result check against the oldest expected particle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            moved_t e;
            if (expected_particles.size() == 0) begin
                $error("unexpected particle on output");
                failed = 1'b1;
            end else begin
                e = expected_particles.pop_front();
                if (m_new_pos_x !== e.px) begin
                    $error("new_pos_x exp %h got %h", e.px, m_new_pos_x); failed = 1'b1;
                end
                if (m_new_pos_y !== e.py) begin
                    $error("new_pos_y exp %h got %h", e.py, m_new_pos_y); failed = 1'b1;
                end
                if (m_new_pos_z !== e.pz) begin
                    $error("new_pos_z exp %h got %h", e.pz, m_new_pos_z); failed = 1'b1;
                end
                if (m_new_vel_x !== e.vx) begin
                    $error("new_vel_x exp %h got %h", e.vx, m_new_vel_x); failed = 1'b1;
                end
                if (m_new_vel_y !== e.vy) begin
                    $error("new_vel_y exp %h got %h", e.vy, m_new_vel_y); failed = 1'b1;
                end
                if (m_new_vel_z !== e.vz) begin
                    $error("new_vel_z exp %h got %h", e.vz, m_new_vel_z); failed = 1'b1;
                end
                if (m_scale_x !== e.sx) begin
                    $error("scale_x exp %h got %h", e.sx, m_scale_x); failed = 1'b1;
                end
                if (m_scale_y !== e.sy) begin
                    $error("scale_y exp %h got %h", e.sy, m_scale_y); failed = 1'b1;
                end
                if (m_scale_z !== e.sz) begin
                    $error("scale_z exp %h got %h", e.sz, m_scale_z); failed = 1'b1;
                end
                if (m_new_age !== e.age) begin
                    $error("new_age exp %h got %h", e.age, m_new_age); failed = 1'b1;
                end
            end
        end
    end

    initial begin
        row_t   rows[$];
        row_t   w;
        moved_t nil;
        logic [62:0] big;
        nil = '{default: '0};
        failed = 1'b0;
        quiet = 1'b0;
        hold_sink = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0;
        {s_pos_x, s_pos_y, s_pos_z, s_vel_x, s_vel_y, s_vel_z} = '0;
        {s_spawn_scale_x, s_spawn_scale_y, s_spawn_scale_z, s_age, s_time_step} = '0;
        accel_q = RST_FIELD_ACCEL; box_lo_q = RST_BOX_MIN; box_hi_q = RST_BOX_MAX;
        end_scale_q = RST_END_SCALE; floor_q = 0; life_q = RST_LIFE_SPAN;
        flags_q = RST_MODE_FLAGS;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows under reset settings (move only)
        // zero particle with zero step stays put
        w.p = '{default: '0}; w.check_fixed = 1; w.r = nil; rows.insert(rows.size(), w);
        // constant velocity one second: pos += vel, age += 1.0
        w.p = '{32'h10000, 0, 0, 32'h20000, 0, 0, 24'h10000, 0, 0, 0, 17'h10000};
        w.check_fixed = 1;
        w.r = '{32'h30000, 0, 0, 32'h20000, 0, 0, 32'h10000, 0, 0, 31'h10000};
        rows.insert(rows.size(), w);
        // position saturates high and low
        w.p = '{32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 0,
                24'h7fffff, 24'h800000, 0, 31'h7fffffff, 17'h1ffff};
        w.check_fixed = 0; rows.insert(rows.size(), w);
        // age saturates
        w.p = '{default: '0}; w.p.age = 31'h7fffffff; w.p.dt = 17'h10000;
        w.check_fixed = 1; w.r = nil; w.r.age = 31'h7fffffff; rows.insert(rows.size(), w);
        foreach (rows[i]) send_particle(rows[i].p, rows[i].check_fixed, rows[i].r);
        drain();

        // all features on, small box around origin, floor at zero
        write_reg(REG_MODE_FLAGS, 63'hf);
        write_reg(REG_FIELD_ACCEL, {21'h1ffc00, 21'h1ff000, 21'h000400});
        write_reg(REG_FIELD_BOXMIN, {3{21'h1ffc00}});
        write_reg(REG_FIELD_BOXMAX, {3{21'h000400}});
        write_reg(REG_END_SCALE, {21'h000800, 21'h1ff800, 21'h0fffff});
        write_reg(REG_FLOOR, 63'h0);
        write_reg(REG_LIFE_SPAN, 63'h20000);
        rows.delete();
        // inside box, below floor: kick and bounce
        w.p = '{32'h8000, 32'hffff8000, 32'h0, 32'h10000, 32'hfffe0000, 0,
                24'h10000, 24'h8000, 24'hfff000, 31'h10000, 17'h8000};
        w.check_fixed = 0; rows.insert(rows.size(), w);
        // on the box edge: no kick
        w.p.px = 32'h10000; rows.insert(rows.size(), w);
        // exactly at floor after move
        w.p = '{0, 32'h10000, 0, 0, 32'hffff0000, 0, 0, 0, 0, 31'h40000, 17'h10000};
        rows.insert(rows.size(), w);
        // vertical velocity extremes under bounce
        w.p.vy = 32'h80000000; w.p.py = 32'h80000000; rows.insert(rows.size(), w);
        w.p.vy = 32'h7fffffff; rows.insert(rows.size(), w);
        // age far beyond life: blend extrapolates and saturates
        w.p = '{0, 32'h100000, 0, 0, 0, 0, 24'h7fffff, 24'h800000, 24'h123456,
                31'h7fffffff, 17'h1ffff};
        rows.insert(rows.size(), w);
        foreach (rows[i]) send_particle(rows[i].p, 0, nil);
        drain();
        // zero life span acts as one
        write_reg(REG_LIFE_SPAN, 63'h0);
        send_particle(rows[5].p, 0, nil);
        send_particle(rows[0].p, 0, nil);
        drain();

        // random phases through several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_MODE_FLAGS, 63'($urandom_range(0, 15)));
            if (ph == 5) write_reg(REG_MODE_FLAGS, 63'hf);
            big = 63'({$urandom, $urandom});
            write_reg(REG_FIELD_ACCEL, (ph == 1) ? {63{1'b1}} : big);
            write_reg(REG_FIELD_BOXMIN, (ph == 2) ? 63'h0 :
                      {21'h1f0000 | 21'($urandom), 21'h1f0000 | 21'($urandom),
                       21'h1f0000 | 21'($urandom)});
            write_reg(REG_FIELD_BOXMAX, (ph == 2) ? {63{1'b1}} :
                      {21'($urandom_range(0, 65535)), 21'($urandom_range(0, 65535)),
                       21'($urandom_range(0, 65535))});
            write_reg(REG_END_SCALE, (ph == 3) ? 63'h0 : 63'({$urandom, $urandom}));
            write_reg(REG_FLOOR, (ph == 4) ? 63'h7fffffff : (ph == 3) ? 63'h80000000 :
                      63'($signed($urandom_range(0, 131072)) - 65536));
            write_reg(REG_LIFE_SPAN, (ph == 1) ? 63'h7fffffff : (ph == 4) ? 63'h1 :
                      63'($urandom_range(1, 400000)));
            // long receiver hold-off while the sender keeps pushing
            if (ph == 2) begin
                hold_cycles = 200;
                hold_sink = 1'b1;
            end
            quiet = (ph == 5);
            for (int n = 0; n < 92; n++) send_particle(rand_particle(), 0, nil);
            drain();
        end

        if (!failed) begin
            $display("[particle_motion_step_unit] OK");
        end else begin
            $display("[particle_motion_step_unit] ERROR");
        end
        $finish;
    end
endmodule
